>>> rtl/core/mesh_normal_generator_top_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the mesh normal generator
// Shared by the modules that check their own control logic.
// ---------------------------------------------------------------------------
`ifndef MESH_NORMAL_GENERATOR_TOP_DEFINES_SVH
`define MESH_NORMAL_GENERATOR_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MNG_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MNG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/mng_pkg.sv
// ---------------------------------------------------------------------------
// mng_pkg
// Constants, codes and the command and status types of the normal generator.
// ---------------------------------------------------------------------------
`default_nettype none

package mng_pkg;

  localparam int VERTEX_DEPTH = 1024;
  localparam int IDX_W        = $clog2(VERTEX_DEPTH);
  localparam int POS_W        = 16;
  localparam int NORM_W       = 16;
  localparam int CROSS_W      = 35;
  localparam int MS_W         = 30;
  localparam int SQ_W         = 62;
  localparam int LEN_W        = 32;
  localparam int NUM_W        = 48;
  localparam int SUM_W        = 32;
  localparam int CNT_W        = 16;
  localparam int ACC_W        = CNT_W + 3 * SUM_W;
  localparam int STEP_W       = 6;
  localparam int SQRT_STEPS   = 31;
  localparam int DIV_STEPS    = 48;

  localparam logic [NORM_W-1:0] NORM_ONE  = 16'd16384;
  localparam logic [CNT_W-1:0]  COUNT_MAX = 16'hFFFF;

  localparam logic [1:0] REQ_LOAD = 2'd0;
  localparam logic [1:0] REQ_FACE = 2'd1;
  localparam logic [1:0] REQ_READ = 2'd2;

  localparam logic KIND_FACE = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // Corner selector code that addresses the request's own vertex index.
  localparam logic [1:0] SEL_IDX = 2'd3;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_POS_RD,
    OP_CROSS,
    OP_SQ,
    OP_SQRT_INIT,
    OP_SQRT_STEP,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_DIV_DONE,
    OP_SUM_RD,
    OP_SUM_WR,
    OP_OUT_FACE,
    OP_OUT_READ
  } mng_op_t;

  typedef struct packed {
    logic              capture;
    mng_op_t           op;
    logic [STEP_W-1:0] step;
  } mng_cmd_t;

  typedef struct packed {
    logic deg;
    logic cnt_zero;
    logic out_busy;
  } mng_stat_t;

  typedef struct packed {
    logic [1:0]              req;
    logic [IDX_W-1:0]        idx;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic [IDX_W-1:0]        corner_a;
    logic [IDX_W-1:0]        corner_b;
    logic [IDX_W-1:0]        corner_c;
  } mng_item_t;

endpackage

`default_nettype wire

>>> rtl/core/mng_dp.sv
// ---------------------------------------------------------------------------
// mng_dp
// Datapath: vertex stores, cross product, square root, divider, output reg.
// ---------------------------------------------------------------------------
`default_nettype none
`include "mesh_normal_generator_top_defines.svh"

module mng_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  mng_pkg::mng_cmd_t    cmd,
  input  mng_pkg::mng_item_t   item,
  output mng_pkg::mng_stat_t   stat,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [47:0]          m_tdata,
  output logic [1:0]           m_tuser
);
  import mng_pkg::*;

  mng_item_t                it;
  logic [IDX_W-1:0]         cor_sel;

  logic [3*POS_W-1:0]       pos_mem [VERTEX_DEPTH];
  logic [3*POS_W-1:0]       pos_q;
  logic                     rd_pend;
  logic [1:0]               rd_slot;
  logic signed [POS_W-1:0]  vtx [3][3];

  logic signed [POS_W:0]    e1 [3];
  logic signed [POS_W:0]    e2 [3];
  logic signed [POS_W:0]    mul_a;
  logic signed [POS_W:0]    mul_b;
  logic signed [2*POS_W+1:0] prod;
  logic                     prod_pend;
  logic [2:0]               prod_sel;
  logic signed [CROSS_W-1:0] cr [3];

  logic [CROSS_W-1:0]       mg [3];
  logic [CROSS_W-1:0]       mmax;
  logic [2:0]               shamt;
  logic [MS_W-1:0]          ms [3];
  logic [1:0]               sidx;
  logic [2*MS_W-1:0]        sq;
  logic                     sq_pend;
  logic [SQ_W-1:0]          acc;

  logic [SQ_W-1:0]          sqn;
  logic [SQ_W-1:0]          sqres;
  logic [SQ_W-1:0]          sqbit;
  logic [SQ_W-1:0]          trial;
  logic [LEN_W-1:0]         len;

  logic [NUM_W-1:0]         dnum;
  logic [LEN_W-1:0]         ddvs;
  logic [LEN_W-1:0]         drem;
  logic [NORM_W-1:0]        dquo;
  logic [LEN_W:0]           dshift;
  logic                     dge;
  logic [1:0]               comp;
  logic                     src_read;
  logic signed [SUM_W-1:0]  sum_sel;
  logic [SUM_W-1:0]         sum_mag;
  logic [NORM_W-1:0]        qcap;
  logic                     qneg;
  logic signed [NORM_W-1:0] nrm [3];

  logic [ACC_W-1:0]         acc_mem [VERTEX_DEPTH];
  logic [ACC_W-1:0]         sum_q;
  logic [CNT_W-1:0]         cnt_q;
  logic                     wr_en;
  logic [IDX_W-1:0]         wr_addr;
  logic [ACC_W-1:0]         wr_data;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      it <= item;
    end
  end

  always_comb begin
    case (cmd.step[1:0])
      2'd0:    cor_sel = it.corner_a;
      2'd1:    cor_sel = it.corner_b;
      2'd2:    cor_sel = it.corner_c;
      default: cor_sel = it.idx;
    endcase
  end

  // Position store; read data passes through pos_q into a corner register.
  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD) begin
      pos_mem[it.idx] <= {it.pos_z, it.pos_y, it.pos_x};
    end
    if (cmd.op == OP_POS_RD) begin
      pos_q <= pos_mem[cor_sel];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
      rd_slot <= 2'd0;
    end else begin
      rd_pend <= (cmd.op == OP_POS_RD);
      rd_slot <= cmd.step[1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_pend) begin
      for (int k = 0; k < 3; k++) begin
        vtx[rd_slot][k] <= pos_q[k*POS_W +: POS_W];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      e1[k] = 17'(vtx[0][k]) - 17'(vtx[1][k]);
      e2[k] = 17'(vtx[0][k]) - 17'(vtx[2][k]);
    end
  end

  // Six products, one per step; odd steps subtract from the even ones.
  always_comb begin
    case (cmd.step[2:0])
      3'd0:    begin mul_a = e1[1]; mul_b = e2[2]; end
      3'd1:    begin mul_a = e1[2]; mul_b = e2[1]; end
      3'd2:    begin mul_a = e1[2]; mul_b = e2[0]; end
      3'd3:    begin mul_a = e1[0]; mul_b = e2[2]; end
      3'd4:    begin mul_a = e1[0]; mul_b = e2[1]; end
      3'd5:    begin mul_a = e1[1]; mul_b = e2[0]; end
      default: begin mul_a = '0;    mul_b = '0;    end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_pend <= 1'b0;
      prod_sel  <= 3'd0;
      sq_pend   <= 1'b0;
    end else begin
      prod_pend <= (cmd.op == OP_CROSS);
      prod_sel  <= cmd.step[2:0];
      sq_pend   <= (cmd.op == OP_SQ) && (cmd.step != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_CROSS) begin
      prod <= mul_a * mul_b;
    end
    if (prod_pend) begin
      if (!prod_sel[0]) begin
        cr[prod_sel[2:1]] <= 35'(prod);
      end else begin
        cr[prod_sel[2:1]] <= cr[prod_sel[2:1]] - 35'(prod);
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mg[k] = cr[k][CROSS_W-1] ? 35'(-cr[k]) : 35'(cr[k]);
    end
    mmax = mg[0];
    if (mg[1] > mmax) mmax = mg[1];
    if (mg[2] > mmax) mmax = mg[2];
    if (mmax[34])      shamt = 3'd5;
    else if (mmax[33]) shamt = 3'd4;
    else if (mmax[32]) shamt = 3'd3;
    else if (mmax[31]) shamt = 3'd2;
    else if (mmax[30]) shamt = 3'd1;
    else               shamt = 3'd0;
  end

  assign sidx = cmd.step[1:0] - 2'd1;

  // Each square is registered in the cycle after its step and is added the cycle after that.
  always_ff @(posedge clk) begin
    if (cmd.op == OP_SQ && cmd.step == '0) begin
      for (int k = 0; k < 3; k++) begin
        ms[k] <= MS_W'(mg[k] >> shamt);
      end
      acc <= '0;
    end else if (sq_pend) begin
      acc <= acc + SQ_W'(sq);
    end
    if (cmd.op == OP_SQ && cmd.step != '0) begin
      sq <= ms[sidx] * ms[sidx];
    end
  end

  // Integer square root, one result bit per step.
  assign trial = sqres + sqbit;

  always_ff @(posedge clk) begin
    if (cmd.op == OP_SQRT_INIT) begin
      sqn   <= acc;
      sqres <= '0;
      sqbit <= SQ_W'(1) << (SQ_W - 2);
    end else if (cmd.op == OP_SQRT_STEP) begin
      if (sqn >= trial) begin
        sqn   <= sqn - trial;
        sqres <= (sqres >> 1) + sqbit;
      end else begin
        sqres <= sqres >> 1;
      end
      sqbit <= sqbit >> 2;
    end
  end

  assign len = (sqres[LEN_W-1:0] == '0) ? LEN_W'(1) : sqres[LEN_W-1:0];

  // Restoring divider, one quotient bit per step; only the low bits are kept.
  assign comp     = cmd.step[1:0];
  assign src_read = cmd.step[2];
  assign cnt_q    = sum_q[ACC_W-1 -: CNT_W];
  assign dshift   = {drem, dnum[NUM_W-1]};
  assign dge      = (dshift >= 33'(ddvs));

  always_comb begin
    case (comp)
      2'd0:    sum_sel = sum_q[SUM_W-1:0];
      2'd1:    sum_sel = sum_q[2*SUM_W-1:SUM_W];
      default: sum_sel = sum_q[3*SUM_W-1:2*SUM_W];
    endcase
    sum_mag = sum_sel[SUM_W-1] ? 32'(-sum_sel) : 32'(sum_sel);
    if (src_read) begin
      qcap = dquo;
      qneg = sum_sel[SUM_W-1];
    end else begin
      qcap = (dquo > NORM_ONE) ? NORM_ONE : dquo;
      qneg = cr[comp][CROSS_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_DIV_INIT) begin
      if (src_read) begin
        dnum <= NUM_W'({sum_mag, 1'b0}) + NUM_W'(cnt_q);
        ddvs <= LEN_W'({cnt_q, 1'b0});
      end else begin
        dnum <= NUM_W'({ms[comp], 14'd0}) + NUM_W'(len >> 1);
        ddvs <= len;
      end
      drem <= '0;
      dquo <= '0;
    end else if (cmd.op == OP_DIV_STEP) begin
      drem <= dge ? LEN_W'(dshift - 33'(ddvs)) : dshift[LEN_W-1:0];
      dquo <= {dquo[NORM_W-2:0], dge};
      dnum <= dnum << 1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_POS_RD && cmd.step == '0) begin
      for (int k = 0; k < 3; k++) begin
        nrm[k] <= '0;
      end
    end else if (cmd.op == OP_DIV_DONE) begin
      nrm[comp] <= qneg ? 16'(-qcap) : 16'(qcap);
    end
  end

  // Normal sums and face count share one store row: {count, z, y, x}.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cor_sel;
    wr_data = '0;
    if (cmd.op == OP_LOAD) begin
      wr_en   = 1'b1;
      wr_addr = it.idx;
    end else if (cmd.op == OP_SUM_WR && cnt_q != COUNT_MAX) begin
      wr_en   = 1'b1;
      wr_data = {cnt_q + 16'd1,
                 sum_q[3*SUM_W-1:2*SUM_W] + 32'(nrm[2]),
                 sum_q[2*SUM_W-1:SUM_W] + 32'(nrm[1]),
                 sum_q[SUM_W-1:0] + 32'(nrm[0])};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      acc_mem[wr_addr] <= wr_data;
    end
    if (cmd.op == OP_SUM_RD) begin
      sum_q <= acc_mem[cor_sel];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.op == OP_OUT_FACE || cmd.op == OP_OUT_READ) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_OUT_FACE) begin
      m_tdata <= {nrm[2], nrm[1], nrm[0]};
      m_tuser <= {stat.deg, KIND_FACE};
    end else if (cmd.op == OP_OUT_READ) begin
      if (stat.cnt_zero) begin
        m_tdata <= '0;
        m_tuser <= {1'b1, KIND_READ};
      end else begin
        m_tdata <= {nrm[2], nrm[1], nrm[0]};
        m_tuser <= {1'b0, KIND_READ};
      end
    end
  end

  assign stat.deg      = (cr[0] == '0) && (cr[1] == '0) && (cr[2] == '0);
  assign stat.cnt_zero = (cnt_q == '0);
  assign stat.out_busy = m_tvalid;

  `MNG_ASSERT_NOW(a_out_free, (cmd.op == OP_OUT_FACE || cmd.op == OP_OUT_READ), !m_tvalid, "result written into a full output register")
  `MNG_ASSERT_NOW(a_sqrt_bit, cmd.op == OP_SQRT_STEP, sqbit != '0, "square root stepped past its last bit")
  `MNG_ASSERT_NOW(a_sum_fresh, cmd.op == OP_SUM_WR, $past(cmd.op) == OP_SUM_RD, "sum update without a fresh read")

endmodule

`default_nettype wire

>>> rtl/core/mng_ctrl.sv
// ---------------------------------------------------------------------------
// mng_ctrl
// Sequencer that steps the datapath through load, face and read requests.
// ---------------------------------------------------------------------------
`default_nettype none
`include "mesh_normal_generator_top_defines.svh"

module mng_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [1:0]         in_req,
  input  mng_pkg::mng_stat_t stat,
  output mng_pkg::mng_cmd_t  cmd
);
  import mng_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_LOAD  = 9'b000000010,
    S_POS   = 9'b000000100,
    S_CROSS = 9'b000001000,
    S_SQ    = 9'b000010000,
    S_SQRT  = 9'b000100000,
    S_DIV   = 9'b001000000,
    S_SUM   = 9'b010000000,
    S_OUT   = 9'b100000000
  } mng_state_t;

  mng_state_t        state;
  mng_state_t        state_next;
  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  logic [1:0]        comp;
  logic [1:0]        comp_next;
  logic [1:0]        req;
  logic              accept;
  logic              is_face;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign is_face  = (req == REQ_FACE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
      comp  <= 2'd0;
      req   <= REQ_LOAD;
    end else begin
      state <= state_next;
      step  <= step_next;
      comp  <= comp_next;
      if (accept) begin
        req <= in_req;
      end
    end
  end

  always_comb begin
    state_next  = state;
    step_next   = step + 6'd1;
    comp_next   = comp;
    cmd.capture = accept;
    cmd.op      = OP_NOP;
    cmd.step    = step;
    unique case (state)
      S_IDLE: begin
        step_next = '0;
        comp_next = 2'd0;
        if (accept) begin
          unique case (in_req)
            REQ_LOAD: state_next = S_LOAD;
            REQ_FACE: state_next = S_POS;
            REQ_READ: state_next = S_SUM;
            default:  state_next = S_IDLE;
          endcase
        end
      end
      S_LOAD: begin
        cmd.op     = OP_LOAD;
        state_next = S_IDLE;
      end
      S_POS: begin
        if (step < 6'd3) begin
          cmd.op = OP_POS_RD;
        end else begin
          state_next = S_CROSS;
          step_next  = '0;
        end
      end
      S_CROSS: begin
        // Products run on steps zero to five; the last sum settles by step seven.
        if (step < 6'd6) begin
          cmd.op = OP_CROSS;
        end else if (step == 6'd7) begin
          state_next = stat.deg ? S_SUM : S_SQ;
          step_next  = '0;
        end
      end
      S_SQ: begin
        if (step < 6'd4) begin
          cmd.op = OP_SQ;
        end else begin
          state_next = S_SQRT;
          step_next  = '0;
        end
      end
      S_SQRT: begin
        cmd.op = (step == '0) ? OP_SQRT_INIT : OP_SQRT_STEP;
        if (step == 6'(SQRT_STEPS)) begin
          state_next = S_DIV;
          step_next  = '0;
          comp_next  = 2'd0;
        end
      end
      S_DIV: begin
        cmd.step = {3'd0, !is_face, comp};
        if (step == '0) begin
          cmd.op = OP_DIV_INIT;
        end else if (step <= 6'(DIV_STEPS)) begin
          cmd.op = OP_DIV_STEP;
        end else begin
          cmd.op    = OP_DIV_DONE;
          step_next = '0;
          comp_next = comp + 2'd1;
          if (comp == 2'd2) begin
            state_next = is_face ? S_SUM : S_OUT;
          end
        end
      end
      S_SUM: begin
        if (is_face) begin
          // Read then write each corner so a repeated corner sees its own update.
          cmd.op   = step[0] ? OP_SUM_WR : OP_SUM_RD;
          cmd.step = step >> 1;
          if (step == 6'd5) begin
            state_next = S_OUT;
          end
        end else if (step == '0) begin
          cmd.op   = OP_SUM_RD;
          cmd.step = 6'(SEL_IDX);
        end else begin
          state_next = stat.cnt_zero ? S_OUT : S_DIV;
          step_next  = '0;
          comp_next  = 2'd0;
        end
      end
      S_OUT: begin
        if (!stat.out_busy) begin
          cmd.op     = is_face ? OP_OUT_FACE : OP_OUT_READ;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `MNG_ASSERT_NOW(a_sqrt_len, state == S_SQRT, step <= 6'(SQRT_STEPS), "square root ran too long")
  `MNG_ASSERT_NOW(a_div_len, state == S_DIV, step <= 6'(DIV_STEPS + 1), "division ran too long")
  `MNG_ASSERT_NEXT(a_load_go, accept && in_req == REQ_LOAD, state == S_LOAD, "load request not started")

endmodule

`default_nettype wire

>>> rtl/core/mesh_normal_generator_top.sv
// ---------------------------------------------------------------------------
// mesh_normal_generator_top
// Face unit normals and averaged vertex normals over a 1024-vertex store.
// ---------------------------------------------------------------------------
// The block handles one request at a time. A face is accepted, then fetches
// its corners, forms the cross product on one shared multiplier, forms the
// sum of squares, takes the bit-serial square root, makes three divisions
// on the shared serial divider, does the read-modify-write of the three
// corner sums and fills the output register; a zero-area face skips the sum
// of squares, the square root and the divisions. A read fetches the vertex
// sums, makes three divisions and fills the output register; a vertex with
// no faces skips the divisions. The output register holds a finished
// result, so the next request is taken while it waits; a second finished
// result waits in the sequencer, which holds the input off until the output
// register is free. Vertex slots must be loaded before a face or read names
// them.
// ---------------------------------------------------------------------------
`default_nettype none

module mesh_normal_generator_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // vertex_index, pos_x, pos_y, pos_z, corner_a, corner_b, corner_c
  input  logic [87:0] s_tdata,
  // req_type
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // norm_x, norm_y, norm_z
  output logic [47:0] m_tdata,
  // result_kind, degenerate
  output logic [1:0]  m_tuser
);
  import mng_pkg::*;

  mng_item_t item;
  mng_cmd_t  cmd;
  mng_stat_t stat;

  always_comb begin
    item.req      = s_tuser;
    item.idx      = s_tdata[9:0];
    item.pos_x    = s_tdata[25:10];
    item.pos_y    = s_tdata[41:26];
    item.pos_z    = s_tdata[57:42];
    item.corner_a = s_tdata[67:58];
    item.corner_b = s_tdata[77:68];
    item.corner_c = s_tdata[87:78];
  end

  mng_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .in_req   (item.req),
    .stat     (stat),
    .cmd      (cmd)
  );

  mng_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .item     (item),
    .stat     (stat),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

`default_nettype wire
